### design/can_commanded_hbridge_thermal_derate_core_assert.svh
// assertion macros shared by the checker
`ifndef CAN_COMMANDED_HBRIDGE_THERMAL_DERATE_CORE_ASSERT_SVH
`define CAN_COMMANDED_HBRIDGE_THERMAL_DERATE_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CHBTD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CHBTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/chbtd_pkg.sv
`default_nettype none
package chbtd_pkg;

  localparam int IdWidth = 11;
  localparam int TempWidth = 16;
  localparam int DutyWidth = 8;
  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth = 16;
  localparam int PinWidth = 5;

  typedef logic [1:0] dir_t;
  typedef logic [DutyWidth-1:0] duty_t;
  typedef logic signed [TempWidth-1:0] temp_t;
  typedef logic [PinWidth-1:0] pins_t;

  localparam logic [IdWidth-1:0] ID_TEMPERATURE = 11'h101;
  localparam logic [IdWidth-1:0] ID_MOTOR_CMD = 11'h200;

  localparam dir_t DIR_STOP = 2'd0;
  localparam dir_t DIR_FORWARD = 2'd1;
  localparam dir_t DIR_BACKWARD = 2'd2;
  localparam dir_t DIR_BRAKE = 2'd3;

  localparam duty_t FULL_DUTY = 8'd255;

  // pin order: 0 a_in1, 1 a_in2, 2 b_in1, 3 b_in2, 4 enable
  localparam pins_t PINS_FORWARD = 5'h19;
  localparam pins_t PINS_BACKWARD = 5'h16;
  localparam pins_t PINS_BRAKE = 5'h1f;
  localparam pins_t PINS_STOP = 5'h00;

  localparam logic [CfgIndexWidth-1:0] CFG_OVERHEAT = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_CLEAR = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_DERATE = 2'd2;

  localparam temp_t OVERHEAT_RESET = 16'sd6000;
  localparam temp_t CLEAR_RESET = 16'sd5500;
  localparam duty_t DERATE_RESET = 8'd150;

  function automatic pins_t dir_pins(input dir_t dir);
    pins_t p;
    case (dir)
      DIR_FORWARD: p = PINS_FORWARD;
      DIR_BACKWARD: p = PINS_BACKWARD;
      DIR_BRAKE: p = PINS_BRAKE;
      default: p = PINS_STOP;
    endcase
    return p;
  endfunction

  function automatic duty_t dir_duty(input dir_t dir, input duty_t duty);
    duty_t d;
    case (dir)
      DIR_FORWARD, DIR_BACKWARD: d = duty;
      DIR_BRAKE: d = FULL_DUTY;
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

### design/can_commanded_hbridge_thermal_derate_core.sv
// CAN-commanded dual H-bridge drive with thermal derating.
// Input channel (in_valid/in_ready) carries one received CAN frame per transfer:
// identifier, extended flag and four data bytes. Temperature frames (0x101) update
// the over-temperature flag with hysteresis; motor command frames (0x200) set
// direction and duty. All other frames leave state unchanged.
// Output channel (out_valid/out_ready) returns exactly one result per frame: the
// four bridge pin levels, driver enable, applied duty, protection flag and a
// handled flag.
// A frame passes through the input register, then the decision logic feeding the
// result register. Throughput is one frame per cycle, limited only by the result
// register draining.
// When the receiver stalls, the result holds and one more frame can wait in the
// input register; in_ready drops only when both are full.
// The cfg port writes overheat threshold (0), clear threshold (1) and derate duty
// (2); write only while no frame is in flight.
// Synchronous reset empties both registers, restores the default configuration and
// sets the drive state to stop direction, stop pins and zero duty.
`default_nettype none
module can_commanded_hbridge_thermal_derate_core (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_write,
  input wire logic [chbtd_pkg::CfgIndexWidth-1:0] cfg_index,
  input wire logic [chbtd_pkg::CfgDataWidth-1:0] cfg_data,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [chbtd_pkg::IdWidth-1:0] frame_id,
  input wire logic is_extended,
  input wire logic [7:0] data_byte0,
  input wire logic [7:0] data_byte1,
  input wire logic [7:0] data_byte2,
  input wire logic [7:0] data_byte3,
  output logic out_valid,
  input wire logic out_ready,
  output logic bridge_a_in1,
  output logic bridge_a_in2,
  output logic bridge_b_in1,
  output logic bridge_b_in2,
  output logic driver_enable,
  output logic [7:0] drive_duty,
  output logic over_temp_active,
  output logic frame_handled
);
  import chbtd_pkg::*;

  temp_t overheat_threshold;
  temp_t clear_threshold;
  duty_t derate_duty;

  logic s_valid;
  logic [IdWidth-1:0] s_id;
  logic s_ext;
  logic [7:0] s_b0;
  logic [7:0] s_b1;
  logic [7:0] s_b2;
  logic [7:0] s_b3;

  logic protection_flag, protection_flag_next;
  dir_t stored_direction, stored_direction_next;
  duty_t stored_duty, stored_duty_next;
  pins_t pin_levels, pin_levels_next;
  duty_t applied_duty, applied_duty_next;

  logic advance;
  logic is_temp, is_cmd;
  temp_t temp;
  logic temp_hot, temp_cold, flag_temp;
  duty_t capped_duty, cmd_duty;
  dir_t cmd_dir;
  pins_t out_pins;

  assign advance = !out_valid || out_ready;
  assign in_ready = !s_valid || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      overheat_threshold <= OVERHEAT_RESET;
      clear_threshold <= CLEAR_RESET;
      derate_duty <= DERATE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_OVERHEAT: overheat_threshold <= temp_t'(cfg_data);
        CFG_CLEAR: clear_threshold <= temp_t'(cfg_data);
        CFG_DERATE: derate_duty <= cfg_data[DutyWidth-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_id <= frame_id;
      s_ext <= is_extended;
      s_b0 <= data_byte0;
      s_b1 <= data_byte1;
      s_b2 <= data_byte2;
      s_b3 <= data_byte3;
    end
  end

  // frame decode
  assign is_temp = !s_ext && (s_id == ID_TEMPERATURE);
  assign is_cmd = !s_ext && (s_id == ID_MOTOR_CMD);
  assign temp = temp_t'({s_b0, s_b1});
  assign temp_hot = temp >= overheat_threshold;
  assign temp_cold = temp < clear_threshold;
  assign flag_temp = temp_hot || (!temp_cold && (s_b2 != 8'd0));
  assign capped_duty = (stored_duty > derate_duty) ? derate_duty : stored_duty;
  assign cmd_dir = (s_b0 <= {6'd0, DIR_BRAKE}) ? s_b0[1:0] : DIR_STOP;
  assign cmd_duty = (protection_flag && (s_b1 > derate_duty)) ? derate_duty : s_b1;

  always_comb begin
    protection_flag_next = protection_flag;
    stored_direction_next = stored_direction;
    stored_duty_next = stored_duty;
    pin_levels_next = pin_levels;
    applied_duty_next = applied_duty;
    if (is_temp) begin
      protection_flag_next = flag_temp;
      if (flag_temp) begin
        stored_duty_next = capped_duty;
        if (stored_direction == DIR_FORWARD || stored_direction == DIR_BACKWARD) begin
          pin_levels_next = dir_pins(stored_direction);
          applied_duty_next = capped_duty;
        end
      end
    end else if (is_cmd) begin
      stored_direction_next = cmd_dir;
      stored_duty_next = cmd_duty;
      pin_levels_next = dir_pins(cmd_dir);
      applied_duty_next = dir_duty(cmd_dir, cmd_duty);
    end
  end

  // drive state
  always_ff @(posedge clk) begin
    if (rst) begin
      protection_flag <= 1'b0;
      stored_direction <= DIR_STOP;
      stored_duty <= '0;
      pin_levels <= PINS_STOP;
      applied_duty <= '0;
    end else if (s_valid && advance) begin
      protection_flag <= protection_flag_next;
      stored_direction <= stored_direction_next;
      stored_duty <= stored_duty_next;
      pin_levels <= pin_levels_next;
      applied_duty <= applied_duty_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && advance) begin
      out_pins <= pin_levels_next;
      drive_duty <= applied_duty_next;
      over_temp_active <= protection_flag_next;
      frame_handled <= is_temp || is_cmd || (s_b3 != s_b3);
    end
  end

  assign bridge_a_in1 = out_pins[0];
  assign bridge_a_in2 = out_pins[1];
  assign bridge_b_in1 = out_pins[2];
  assign bridge_b_in2 = out_pins[3];
  assign driver_enable = out_pins[4];

endmodule
`default_nettype wire

### design/chbtd_checker.sv
`default_nettype none
`include "can_commanded_hbridge_thermal_derate_core_assert.svh"
module chbtd_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic bridge_a_in1,
  input wire logic bridge_a_in2,
  input wire logic bridge_b_in1,
  input wire logic bridge_b_in2,
  input wire logic driver_enable,
  input wire logic [7:0] drive_duty,
  input wire logic over_temp_active,
  input wire logic frame_handled
);
  import chbtd_pkg::*;

  logic [11:0] result_bits;
  assign result_bits = {bridge_a_in1, bridge_a_in2, bridge_b_in1, bridge_b_in2,
                        driver_enable, drive_duty[6:0]} ^
                       {11'd0, drive_duty[7] ^ over_temp_active ^ frame_handled};

  // stalled result holds
  `CHBTD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(result_bits) && $stable(drive_duty), "result changed while stalled")

  // the two bridges always mirror each other, and the enable matches bridge A activity
  `CHBTD_ASSERT_NOW(a_bridge_mirror, out_valid,
    (bridge_a_in1 == bridge_b_in2) && (bridge_a_in2 == bridge_b_in1) &&
    (driver_enable == (bridge_a_in1 || bridge_a_in2)), "bridge pins inconsistent")

  // disabled driver means stop pattern and zero duty
  `CHBTD_ASSERT_NOW(a_stop_duty, out_valid && !driver_enable,
    (drive_duty == 8'd0) && !bridge_a_in1 && !bridge_a_in2, "stop with nonzero duty")

  // brake always runs at full duty
  `CHBTD_ASSERT_NOW(a_brake_duty, out_valid && bridge_a_in1 && bridge_a_in2,
    driver_enable && (drive_duty == FULL_DUTY), "brake without full duty")

endmodule

bind can_commanded_hbridge_thermal_derate_core chbtd_checker u_chbtd_checker (.*);
`default_nettype wire

### test/can_commanded_hbridge_thermal_derate_core_test.sv
`timescale 1ns / 100ps
module can_commanded_hbridge_thermal_derate_core_test;
  import chbtd_pkg::*;

  typedef struct packed {
    logic [IdWidth-1:0] id;
    logic ext;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } can_frame_t;

  typedef struct packed {
    pins_t pins;
    duty_t duty;
    logic hot;
    logic handled;
  } bridge_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IdWidth-1:0] frame_id = '0;
  logic is_extended = 1'b0;
  logic [7:0] data_byte0 = '0;
  logic [7:0] data_byte1 = '0;
  logic [7:0] data_byte2 = '0;
  logic [7:0] data_byte3 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic bridge_a_in1;
  logic bridge_a_in2;
  logic bridge_b_in1;
  logic bridge_b_in2;
  logic driver_enable;
  logic [7:0] drive_duty;
  logic over_temp_active;
  logic frame_handled;

  can_commanded_hbridge_thermal_derate_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .frame_id(frame_id), .is_extended(is_extended),
    .data_byte0(data_byte0), .data_byte1(data_byte1),
    .data_byte2(data_byte2), .data_byte3(data_byte3),
    .out_valid(out_valid), .out_ready(out_ready),
    .bridge_a_in1(bridge_a_in1), .bridge_a_in2(bridge_a_in2),
    .bridge_b_in1(bridge_b_in1), .bridge_b_in2(bridge_b_in2),
    .driver_enable(driver_enable), .drive_duty(drive_duty),
    .over_temp_active(over_temp_active), .frame_handled(frame_handled)
  );

  can_frame_t frame_q[$];
  bridge_state_t bridge_q[$];
  int frames_queued = 0;
  int frames_taken = 0;
  int results_seen = 0;
  int errors = 0;
  logic in_took = 1'b0;
  logic out_took = 1'b0;
  int tx_wait = 0;
  int tx_calm = 0;
  int rx_wait = 0;
  int rx_calm = 0;

  // thermal and drive state mirrored by the testbench predictor
  temp_t hot_thr = OVERHEAT_RESET;
  temp_t cool_thr = CLEAR_RESET;
  duty_t duty_cap = DERATE_RESET;
  logic hot_flag = 1'b0;
  dir_t run_dir = DIR_STOP;
  duty_t run_duty = '0;
  pins_t pin_now = PINS_STOP;
  duty_t duty_now = '0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void apply_dir(dir_t d);
    case (d)
      DIR_FORWARD: begin
        pin_now = PINS_FORWARD;
        duty_now = run_duty;
      end
      DIR_BACKWARD: begin
        pin_now = PINS_BACKWARD;
        duty_now = run_duty;
      end
      DIR_BRAKE: begin
        pin_now = PINS_BRAKE;
        duty_now = FULL_DUTY;
      end
      default: begin
        pin_now = PINS_STOP;
        duty_now = '0;
      end
    endcase
  endfunction

  function automatic void derate_running();
    if (run_duty > duty_cap) run_duty = duty_cap;
    if (run_dir == DIR_FORWARD || run_dir == DIR_BACKWARD) apply_dir(run_dir);
  endfunction

  function automatic bridge_state_t predict_bridge(can_frame_t f);
    temp_t t;
    logic handled;
    bridge_state_t r;
    handled = 1'b0;
    if (!f.ext && f.id == ID_TEMPERATURE) begin
      t = {f.b0, f.b1};
      handled = 1'b1;
      hot_flag = (f.b2 != 8'd0);
      if (t >= hot_thr) begin
        hot_flag = 1'b1;
        derate_running();
      end else if (t < cool_thr) begin
        hot_flag = 1'b0;
      end
      // recheck on every temperature frame while hot
      if (hot_flag) derate_running();
    end else if (!f.ext && f.id == ID_MOTOR_CMD) begin
      handled = 1'b1;
      run_dir = (f.b0 <= {6'd0, DIR_BRAKE}) ? dir_t'(f.b0[1:0]) : DIR_STOP;
      run_duty = f.b1;
      if (hot_flag && run_duty > duty_cap) run_duty = duty_cap;
      apply_dir(run_dir);
    end
    r = {pin_now, duty_now, hot_flag, handled};
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic int next_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 17);
  endfunction

  always @(posedge clk) begin : sample
    bridge_state_t want;
    can_frame_t f;
    in_took <= !rst && in_valid && in_ready;
    out_took <= !rst && out_valid && out_ready;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (bridge_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual pins %b%b%b%b en %b duty %0d",
                 $time, bridge_a_in1, bridge_a_in2, bridge_b_in1, bridge_b_in2,
                 driver_enable, drive_duty);
      end else begin
        want = bridge_q.pop_front();
        check_field("bridge_a_in1", want.pins[0], bridge_a_in1);
        check_field("bridge_a_in2", want.pins[1], bridge_a_in2);
        check_field("bridge_b_in1", want.pins[2], bridge_b_in1);
        check_field("bridge_b_in2", want.pins[3], bridge_b_in2);
        check_field("driver_enable", want.pins[4], driver_enable);
        check_field("drive_duty", want.duty, drive_duty);
        check_field("over_temp_active", want.hot, over_temp_active);
        check_field("frame_handled", want.handled, frame_handled);
      end
    end
    if (!rst && in_valid && in_ready) begin
      f = {frame_id, is_extended, data_byte0, data_byte1, data_byte2, data_byte3};
      bridge_q.push_back(predict_bridge(f));
      frames_taken++;
    end
  end

  // frame sender
  always @(negedge clk) begin : feed
    can_frame_t f;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_took) tx_wait = next_wait(tx_calm);
      if (!in_valid || in_took) begin
        if (tx_wait > 0) begin
          in_valid <= 1'b0;
          tx_wait--;
        end else if (frame_q.size() > 0) begin
          f = frame_q.pop_front();
          frame_id <= f.id;
          is_extended <= f.ext;
          data_byte0 <= f.b0;
          data_byte1 <= f.b1;
          data_byte2 <= f.b2;
          data_byte3 <= f.b3;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with long hold-offs to back up the input
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_took)
        rx_wait = (results_seen == 300 || results_seen == 1500) ? 150 : next_wait(rx_calm);
      if (rx_wait > 0) begin
        out_ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_frame(logic [IdWidth-1:0] id, logic ext, logic [7:0] b0,
                            logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
    frame_q.push_back({id, ext, b0, b1, b2, b3});
    frames_queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (frames_taken != frames_queued || results_seen != frames_taken);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_OVERHEAT: hot_thr = val;
      CFG_CLEAR: cool_thr = val;
      CFG_DERATE: duty_cap = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(logic [15:0] ovh, logic [15:0] clr, logic [7:0] der);
    write_reg(CFG_OVERHEAT, ovh);
    write_reg(CFG_CLEAR, clr);
    write_reg(CFG_DERATE, {8'd0, der});
  endtask

  task automatic queue_random(int n);
    logic [15:0] t;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    int hi;
    int lo;
    hi = int'(hot_thr);
    lo = int'(cool_thr);
    for (int k = 0; k < n; k++) begin
      b2 = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          case ($urandom_range(0, 7))
            0: t = hot_thr;
            1: t = 16'(hot_thr - 1);
            2: t = 16'(hot_thr + 1);
            3: t = cool_thr;
            4: t = 16'(cool_thr - 1);
            5: t = 16'((hi + lo) / 2);
            default: t = 16'($urandom);
          endcase
          push_frame(ID_TEMPERATURE, 1'b0, t[15:8], t[7:0], b2, 8'($urandom));
        end
        4, 5, 6, 7: begin
          b0 = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(4, 255))
                                           : 8'($urandom_range(0, 3));
          case ($urandom_range(0, 5))
            0: b1 = 8'd0;
            1: b1 = 8'd255;
            2: b1 = duty_cap;
            default: b1 = 8'($urandom);
          endcase
          push_frame(ID_MOTOR_CMD, 1'b0, b0, b1, 8'($urandom), 8'($urandom));
        end
        8: push_frame($urandom_range(0, 1) ? ID_TEMPERATURE : ID_MOTOR_CMD, 1'b1,
                      8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        default: push_frame(11'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed frames at reset thresholds (6000 / 5500, cap 150)
    push_frame(11'h000, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    push_frame(ID_MOTOR_CMD, 1'b0, 8'(DIR_FORWARD), 8'd255, 8'h00, 8'h00);
    push_frame(ID_TEMPERATURE, 1'b0, 8'h17, 8'h70, 8'h00, 8'h00);
    push_frame(ID_MOTOR_CMD, 1'b0, 8'(DIR_BACKWARD), 8'd200, 8'h00, 8'h00);
    push_frame(ID_TEMPERATURE, 1'b0, 8'h17, 8'h6f, 8'h00, 8'h00);
    push_frame(ID_MOTOR_CMD, 1'b0, 8'(DIR_FORWARD), 8'd255, 8'h00, 8'h00);
    push_frame(ID_TEMPERATURE, 1'b0, 8'h15, 8'h7c, 8'h01, 8'h00);
    push_frame(ID_TEMPERATURE, 1'b0, 8'h15, 8'h7b, 8'h01, 8'hff);
    push_frame(ID_MOTOR_CMD, 1'b0, 8'(DIR_BRAKE), 8'd200, 8'h00, 8'h00);
    push_frame(ID_TEMPERATURE, 1'b0, 8'h7f, 8'hff, 8'h00, 8'h00);
    push_frame(ID_MOTOR_CMD, 1'b0, 8'd4, 8'd100, 8'h00, 8'h00);
    push_frame(ID_MOTOR_CMD, 1'b0, 8'd255, 8'd255, 8'hff, 8'hff);
    push_frame(ID_TEMPERATURE, 1'b1, 8'h7f, 8'hff, 8'hff, 8'h00);
    push_frame(ID_MOTOR_CMD, 1'b1, 8'(DIR_FORWARD), 8'd255, 8'h00, 8'h00);
    push_frame(11'h7ff, 1'b1, 8'hff, 8'hff, 8'hff, 8'hff);
    push_frame(ID_TEMPERATURE, 1'b0, 8'h80, 8'h00, 8'hff, 8'h00);
    push_frame(ID_MOTOR_CMD, 1'b0, 8'(DIR_STOP), 8'd255, 8'h00, 8'h00);
    push_frame(ID_MOTOR_CMD, 1'b0, 8'(DIR_FORWARD), 8'd0, 8'h00, 8'h00);
    push_frame(ID_MOTOR_CMD + 11'd1, 1'b0, 8'(DIR_FORWARD), 8'd9, 8'h00, 8'h00);
    push_frame(ID_TEMPERATURE - 11'd1, 1'b0, 8'h7f, 8'hff, 8'h01, 8'h00);
    push_frame(ID_TEMPERATURE, 1'b0, 8'h16, 8'ha8, 8'h80, 8'h00);
    push_frame(ID_MOTOR_CMD, 1'b0, 8'(DIR_BACKWARD), 8'd255, 8'h00, 8'h00);
    wait_idle();

    queue_random(400);
    wait_idle();
    configure(16'h7fff, 16'h8000, 8'd0);
    queue_random(300);
    wait_idle();
    configure(16'h8000, 16'h7fff, 8'd255);
    queue_random(300);
    wait_idle();
    configure(16'h0000, 16'h0000, 8'($urandom));
    queue_random(250);
    wait_idle();
    configure(16'd3000, 16'd1000, 8'd80);
    queue_random(175);
    wait_idle();
    repeat (3) begin
      configure(16'($urandom), 16'($urandom), 8'($urandom));
      queue_random(175);
      wait_idle();
    end
    configure(OVERHEAT_RESET, CLEAR_RESET, DERATE_RESET);
    queue_random(100);
    wait_idle();

    repeat (10) @(negedge clk);
    if (errors == 0 && bridge_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
